FILE: hw/rtl/smrq_pkg.sv
// Shared types, codes and constants of the slotted message ring queue.
package smrq_pkg;

  // Default geometry of the ring.
  localparam int unsigned NumSlotsDef  = 16;
  localparam int unsigned MaxMsgLenDef = 64;

  // Fixed field widths of the beats.
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 7;
  localparam int unsigned ByteW   = 8;

  // Input kinds.
  localparam logic [KindW-1:0] KIND_WRITE    = 3'd0;
  localparam logic [KindW-1:0] KIND_READ     = 3'd1;
  localparam logic [KindW-1:0] KIND_CLOSE_RD = 3'd2;
  localparam logic [KindW-1:0] KIND_CLOSE_WR = 3'd3;
  localparam logic [KindW-1:0] KIND_INIT     = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY   = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd2;
  localparam logic [StatusW-1:0] ST_CLOSED  = 3'd3;
  localparam logic [StatusW-1:0] ST_BADLEN  = 3'd4;

  // One input beat.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    length_or_slot;
    logic [ByteW-1:0]   out_byte;
    logic               last_out;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               stage;        // store one write byte
    logic [ByteW-1:0]   wr_data;
    logic               clear_stage;  // end of a write message
    logic               commit;       // commit the staged slot
    logic               emit_single;  // one-beat result with status below
    logic               emit_slot;    // single result carries slot plus one
    logic [StatusW-1:0] status;
    logic               emit_stream;  // result carries the current read byte
    logic               rd_start;     // fetch length and first byte
    logic               rd_next;      // fetch next byte
    logic               rd_done;      // advance read pointer
    logic               close_rd;
    logic               close_wr;
    logic               init;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic closed;       // either closed flag set
    logic empty;        // pointers equal
    logic full;         // slot after write pointer is the read pointer
    logic bad_len;      // current write byte overflows or already overflowed
    logic stream_last;  // current read byte is the final one
  } sts_t;

endpackage

FILE: hw/rtl/slotted_message_ring_queue_top.sv
// Top level of the slotted message ring queue.
//
// A ring of NUM_SLOTS message slots of up to MAX_MSG_LEN bytes each; one slot
// always stays free. An input beat on item_i is taken at a clock edge where
// start is high and busy is low. Write bytes are taken one per cycle; the
// final byte of a message yields one result beat the next cycle with status
// ok (and the slot number plus one), bad_length, closed or full.
// A read that finds the queue closed or empty yields one result beat in the
// next cycle. Otherwise busy rises for the length of the message: the length
// is fetched from the length memory along with the first byte, then the byte
// memory is read one byte per cycle, so a message of N bytes gives N result
// beats, one per cycle, and busy stays high until the final byte is issued.
// Close and init beats give no result.
// Each result beat sits on res_o for one cycle, marked by res_valid_o; the
// receiver cannot stall it.
// Reset empties and reopens the queue; message storage keeps its contents and
// needs no clearing pass, so the block takes beats right after reset.
module slotted_message_ring_queue_top #(
  parameter int unsigned NUM_SLOTS   = smrq_pkg::NumSlotsDef,
  parameter int unsigned MAX_MSG_LEN = smrq_pkg::MaxMsgLenDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  smrq_pkg::item_t   item_i,
  output logic              res_valid_o,
  output smrq_pkg::result_t res_o
);

  smrq_pkg::cmd_t cmd;
  smrq_pkg::sts_t sts;

  // Sequencing of beats and read streams.
  smrq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Pointers, slot storage and result register.
  smrq_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_MSG_LEN (MAX_MSG_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

FILE: hw/rtl/smrq_ctrl.sv
// Controller state machine of the slotted message ring queue.
module smrq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  smrq_pkg::item_t item_i,
  input  smrq_pkg::sts_t  sts_i,
  output smrq_pkg::cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_e;

  state_e state_q, state_d;

  // Decode the accepted beat and sequence the read stream.
  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_data = item_i.data_byte;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (item_i.kind)
            smrq_pkg::KIND_WRITE: begin
              cmd_o.stage = 1'b1;
              if (item_i.last_byte) begin
                cmd_o.clear_stage = 1'b1;
                cmd_o.emit_single = 1'b1;
                if (sts_i.bad_len) begin
                  cmd_o.status = smrq_pkg::ST_BADLEN;
                end else if (sts_i.closed) begin
                  cmd_o.status = smrq_pkg::ST_CLOSED;
                end else if (sts_i.full) begin
                  cmd_o.status = smrq_pkg::ST_FULL;
                end else begin
                  cmd_o.status    = smrq_pkg::ST_OK;
                  cmd_o.commit    = 1'b1;
                  cmd_o.emit_slot = 1'b1;
                end
              end
            end
            smrq_pkg::KIND_READ: begin
              if (sts_i.closed) begin
                cmd_o.emit_single = 1'b1;
                cmd_o.status      = smrq_pkg::ST_CLOSED;
              end else if (sts_i.empty) begin
                cmd_o.emit_single = 1'b1;
                cmd_o.status      = smrq_pkg::ST_EMPTY;
              end else begin
                cmd_o.rd_start = 1'b1;
                state_d        = S_STREAM;
              end
            end
            smrq_pkg::KIND_CLOSE_RD: cmd_o.close_rd = 1'b1;
            smrq_pkg::KIND_CLOSE_WR: cmd_o.close_wr = 1'b1;
            smrq_pkg::KIND_INIT:     cmd_o.init     = 1'b1;
            default: ;
          endcase
        end
      end
      S_STREAM: begin
        // One message byte per cycle until the final one.
        cmd_o.emit_stream = 1'b1;
        cmd_o.rd_next     = 1'b1;
        if (sts_i.stream_last) begin
          cmd_o.rd_done = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q == S_STREAM);

endmodule

FILE: hw/rtl/smrq_dp.sv
// Datapath of the slotted message ring queue: pointers, staging, slot memories, result register.
module smrq_dp #(
  parameter int unsigned NUM_SLOTS   = smrq_pkg::NumSlotsDef,
  parameter int unsigned MAX_MSG_LEN = smrq_pkg::MaxMsgLenDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smrq_pkg::cmd_t    cmd_i,
  output smrq_pkg::sts_t    sts_o,
  output logic              res_valid_o,
  output smrq_pkg::result_t res_o
);

  localparam int unsigned PtrW  = $clog2(NUM_SLOTS);
  localparam int unsigned IdxW  = (MAX_MSG_LEN > 1) ? $clog2(MAX_MSG_LEN) : 1;
  localparam int unsigned CntW  = $clog2(MAX_MSG_LEN + 1);
  localparam int unsigned Depth = NUM_SLOTS * (2 ** IdxW);

  localparam logic [PtrW-1:0] LastSlot = PtrW'(NUM_SLOTS - 1);
  localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_MSG_LEN);

  // Control state. A slot holds a committed message exactly when it lies
  // between the read and write pointers, so no per-slot valid mark is kept.
  logic [PtrW-1:0] rp_q, wp_q;
  logic            rd_closed_q, wr_closed_q;
  logic [CntW-1:0] cnt_q;
  logic            ovf_q;
  logic            res_valid_q;

  // Read-out registers.
  logic [CntW-1:0]            rd_len_q;
  logic [CntW-1:0]            rd_idx_q;
  logic [smrq_pkg::ByteW-1:0] rd_byte_q;
  smrq_pkg::result_t          res_q, res_d;

  // Slot memories.
  logic [smrq_pkg::ByteW-1:0] byte_mem [Depth];
  logic [CntW-1:0]            len_mem  [NUM_SLOTS];

  logic [PtrW-1:0]      wp_next, rp_next;
  logic                 cnt_full;
  logic [PtrW+IdxW-1:0] rd_addr;

  assign wp_next  = (wp_q == LastSlot) ? '0 : wp_q + 1'b1;
  assign rp_next  = (rp_q == LastSlot) ? '0 : rp_q + 1'b1;
  assign cnt_full = (cnt_q == MaxCnt);

  // Status back to the controller.
  assign sts_o.closed      = rd_closed_q | wr_closed_q;
  assign sts_o.empty       = (rp_q == wp_q);
  assign sts_o.full        = (wp_next == rp_q);
  assign sts_o.bad_len     = ovf_q | cnt_full;
  assign sts_o.stream_last = (rd_idx_q == rd_len_q);

  // Pointers, closed flags and staging.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      rd_closed_q <= 1'b0;
      wr_closed_q <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
    end else if (cmd_i.init) begin
      rp_q        <= '0;
      wp_q        <= '0;
      rd_closed_q <= 1'b0;
      wr_closed_q <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (cmd_i.close_rd) begin
        rd_closed_q <= 1'b1;
      end
      if (cmd_i.close_wr) begin
        wr_closed_q <= 1'b1;
      end
      if (cmd_i.clear_stage) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.stage) begin
        if (cnt_full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.commit) begin
        wp_q <= wp_next;
      end
      if (cmd_i.rd_done) begin
        rp_q <= rp_next;
      end
    end
  end

  // Byte memory: staged bytes go straight into the slot at the write pointer.
  assign rd_addr = cmd_i.rd_start ? {rp_q, IdxW'(0)} : {rp_q, rd_idx_q[IdxW-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage && !cnt_full) begin
      byte_mem[{wp_q, cnt_q[IdxW-1:0]}] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_start || cmd_i.rd_next) begin
      rd_byte_q <= byte_mem[rd_addr];
    end
  end

  // Length memory: written on commit, read when a stream starts.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      len_mem[wp_q] <= cnt_q + 1'b1;
    end
    if (cmd_i.rd_start) begin
      rd_len_q <= len_mem[rp_q];
    end
  end

  // Byte index of the stream.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_start) begin
      rd_idx_q <= CntW'(1);
    end else if (cmd_i.rd_next) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  // Next result beat.
  always_comb begin
    res_d = '0;
    if (cmd_i.emit_stream) begin
      res_d.status         = smrq_pkg::ST_OK;
      res_d.length_or_slot = smrq_pkg::LenW'(rd_len_q);
      res_d.out_byte       = rd_byte_q;
      res_d.last_out       = sts_o.stream_last;
    end else begin
      res_d.status   = cmd_i.status;
      res_d.last_out = 1'b1;
      if (cmd_i.emit_slot) begin
        res_d.length_or_slot = smrq_pkg::LenW'({1'b0, wp_q} + 1'b1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_single | cmd_i.emit_stream;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A stream starts only on a non-empty, open queue and finishes only on a non-empty one.
  a_rd_start_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_start |-> !sts_o.empty && !sts_o.closed)
    else $error("stream started on an empty or closed queue");

  a_rd_done_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_done |-> !sts_o.empty)
    else $error("read pointer advanced past the write pointer");

  // A commit never fills the last free slot, takes an overlong message or lands on a closed queue.
  a_commit_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !sts_o.full && !sts_o.bad_len && !sts_o.closed)
    else $error("commit on a full, closed or overlong message");

  // A stream byte appears next cycle with the final mark it was issued with.
  a_stream_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_stream |=> res_valid_q && (res_q.last_out == $past(sts_o.stream_last)))
    else $error("stream beat lost or final mark wrong");

endmodule
